// File: sv/totpr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the text page renderer.
// Holds the job record, character codes, command bytes and the 5x7 font table.
package totpr_pkg;

   // Character codes that steer the front end.
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] GLYPH_FIRST = 8'h20;
   localparam logic [7:0] GLYPH_LAST  = 8'h7F;

   // Font row used for bytes that cannot be printed (the question mark).
   localparam logic [6:0] GLYPH_UNKNOWN = 7'd31;

   localparam logic [6:0] CHAR_ADVANCE = 7'd6;

   // Cursor command bytes.
   localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
   localparam logic [7:0] CMD_COL_LOW   = 8'h00;
   localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
   localparam logic [7:0] BLANK_COLUMN  = 8'h00;

   // Output sequence positions; glyph columns use positions 0 to 4.
   localparam logic [3:0] STEP_LAST_GLYPH = 4'd4;
   localparam logic [3:0] STEP_BLANK      = 4'd5;
   localparam logic [3:0] STEP_PAGE       = 4'd6;
   localparam logic [3:0] STEP_COL_LO     = 4'd7;
   localparam logic [3:0] STEP_COL_HI     = 4'd8;

   // One unit of work handed from the front end to the back end.
   typedef struct packed {
      logic       is_glyph;   // 0: line feed, cursor commands only
      logic [6:0] glyph_idx;  // font row
      logic       wrap;       // cursor commands follow the glyph
      logic [2:0] page;       // page after the move
   } job_type;

   // Five columns per glyph, column 0 in the top byte.
   localparam logic [39:0] GLYPH_ROM [0:95] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
      40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
      40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
      40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
      40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
      40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
      40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
      40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
      40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
      40'h7C14141408, 40'h081414147C, 40'h7C08040408, 40'h4854545420,
      40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
      40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
      40'h00007F0000, 40'h0041360800, 40'h0804081008, 40'h0000000000
   };

endpackage

// File: sv/totpr_front.sv
`timescale 1ns / 1ps
// Front end: accepts character bytes, classifies them and moves the cursor.
// Depends on totpr_pkg for the job record and character codes.
module totpr_front
   import totpr_pkg::*;
#(
   parameter int DISPLAY_WIDTH = 128,
   parameter int PAGE_COUNT    = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       queue_full,
   output logic       push,
   output job_type    push_job
);

   localparam logic [7:0] WRAP_AT    = 8'(DISPLAY_WIDTH - 6);
   localparam logic [3:0] PAGE_LIMIT = 4'(PAGE_COUNT);

   logic [6:0] column_ff, column_in;
   logic [2:0] page_ff, page_in;
   logic [2:0] page_next;
   logic [6:0] column_sum;
   logic       accept;
   logic       is_lf;
   logic       is_cr;
   logic       printable;
   logic       wrap;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign is_lf     = (req_char_code == CHAR_LF);
   assign is_cr     = (req_char_code == CHAR_CR);
   assign printable = (req_char_code >= GLYPH_FIRST) && (req_char_code <= GLYPH_LAST);

   always_comb begin
      page_next = page_ff + 3'd1;
      if ({1'b0, page_next} >= PAGE_LIMIT) begin
         page_next = 3'd0;
      end
   end

   assign column_sum = column_ff + CHAR_ADVANCE;
   assign wrap       = ({1'b0, column_sum} >= WRAP_AT);

   always_comb begin
      column_in          = column_ff;
      page_in            = page_ff;
      push               = 1'b0;
      push_job.is_glyph  = !is_lf;
      push_job.glyph_idx = printable ? 7'(req_char_code - GLYPH_FIRST) : GLYPH_UNKNOWN;
      push_job.wrap      = wrap;
      push_job.page      = page_next;
      if (accept && !is_cr) begin
         push = 1'b1;
         if (is_lf || wrap) begin
            column_in = 7'd0;
            page_in   = page_next;
         end else begin
            column_in = column_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= 7'd0;
         page_ff   <= 3'd0;
      end else begin
         column_ff <= column_in;
         page_ff   <= page_in;
      end
   end

endmodule

// File: sv/totpr_queue.sv
`timescale 1ns / 1ps
// Two-entry job queue between the front end and the back end.
// Depends on totpr_pkg for the job record.
module totpr_queue
   import totpr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: sv/totpr_back.sv
`timescale 1ns / 1ps
// Back end: walks a job through its bytes, one per cycle unless stalled.
// Depends on totpr_pkg for the job record, command bytes and font table.
module totpr_back
   import totpr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  job_type    head_job,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_is_data,
   output logic [7:0] rsp_byte_value,
   output logic       rsp_last
);

   logic [3:0]  step_ff, step_in;
   logic        valid_ff, valid_in;
   logic        is_data_ff, is_data_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [3:0]  pos;
   logic [39:0] glyph_row;
   logic        load;
   logic        final_step;

   // Line feed jobs start straight at the page command.
   assign pos       = head_job.is_glyph ? step_ff : step_ff + STEP_PAGE;
   assign glyph_row = GLYPH_ROM[head_job.glyph_idx];
   assign load      = head_valid && (!valid_ff || rsp_ready);
   assign final_step = (pos == STEP_COL_HI) || (!head_job.wrap && pos == STEP_BLANK);
   assign pop       = load && final_step;

   always_comb begin
      is_data_in = (pos <= STEP_BLANK);
      case (pos)
         4'd0:        byte_in = glyph_row[39:32];
         4'd1:        byte_in = glyph_row[31:24];
         4'd2:        byte_in = glyph_row[23:16];
         4'd3:        byte_in = glyph_row[15:8];
         STEP_LAST_GLYPH: byte_in = glyph_row[7:0];
         STEP_BLANK:  byte_in = BLANK_COLUMN;
         STEP_PAGE:   byte_in = CMD_PAGE_BASE | {5'd0, head_job.page};
         STEP_COL_LO: byte_in = CMD_COL_LOW;
         STEP_COL_HI: byte_in = CMD_COL_HIGH;
         default:     byte_in = BLANK_COLUMN;
      endcase
      last_in  = final_step;
      step_in  = load ? (final_step ? 4'd0 : step_ff + 4'd1) : step_ff;
      valid_in = load || (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         is_data_ff <= is_data_in;
         byte_ff    <= byte_in;
         last_ff    <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_is_data    = is_data_ff;
   assign rsp_byte_value = byte_ff;
   assign rsp_last       = last_ff;

endmodule

// File: sv/text_to_oled_page_renderer.sv
`timescale 1ns / 1ps
// Text console renderer for a page-addressed monochrome display, 5x7 font.
// Depends on totpr_pkg, totpr_front, totpr_queue and totpr_back.
//
// The req_ channel carries one character byte per transfer. The rsp_ channel
// carries the resulting display bytes, one per transfer: is_data marks glyph
// column data versus cursor commands, and last flags the final byte caused by
// a character. A byte yields five glyph columns (the question mark if it is
// unprintable) and a blank column, plus three cursor commands on a wrap; a
// line feed yields only the three commands, and a carriage return nothing.
// The front end classifies each character and moves the cursor in the cycle
// it is taken, then hands a job to a two-entry queue. The back end emits one
// byte per cycle while rsp_ready is high, through an output register; a
// character's job passes through a queue slot, then its bytes through that
// register, up to nine bytes per character. The output byte rate is the limit.
// The queue lets new characters be taken while earlier ones are still being
// emitted or while the receiver stalls; when the receiver holds rsp_ready low
// the output holds and the queue fills, after which req_ready drops.
// Reset (synchronous, active high) puts the cursor at column 0, page 0 and
// empties the queue and the output register.
module text_to_oled_page_renderer
   import totpr_pkg::*;
#(
   parameter int DISPLAY_WIDTH = 128,
   parameter int PAGE_COUNT    = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_is_data,
   output logic [7:0] rsp_byte_value,
   output logic       rsp_last
);

   logic    push;
   job_type push_job;
   logic    queue_full;
   logic    pop;
   logic    head_valid;
   job_type head_job;

   // Cursor bookkeeping and classification.
   totpr_front #(
      .DISPLAY_WIDTH(DISPLAY_WIDTH),
      .PAGE_COUNT   (PAGE_COUNT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_char_code(req_char_code),
      .queue_full   (queue_full),
      .push         (push),
      .push_job     (push_job)
   );

   // Decouples character intake from byte output.
   totpr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_job  (head_job)
   );

   // Byte sequencer with the registered output stage.
   totpr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_job      (head_job),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_is_data   (rsp_is_data),
      .rsp_byte_value(rsp_byte_value),
      .rsp_last      (rsp_last)
   );

endmodule

// File: tb/renderer_byte_checker.sv
`timescale 1ns / 1ps
// Checker for the text page renderer: watches both channels, predicts the display bytes.
// Depends on totpr_pkg for the character codes and the cursor command bytes.
module renderer_byte_checker
   import totpr_pkg::*;
#(
   parameter int DISPLAY_WIDTH = 128,
   parameter int PAGE_COUNT    = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_is_data,
   input  logic [7:0] rsp_byte_value,
   input  logic       rsp_last,
   input  logic       drain_done,
   output int         fail_count,
   output int         outstanding,
   output int         bytes_checked
);

   localparam logic [7:0] CHAR_QUESTION = 8'h3F;

   typedef struct packed {
      logic       is_data;
      logic [7:0] value;
      logic       last;
   } disp_byte_type;

   // 5x7 font, codes 0x20 to 0x7F, leftmost column in the top byte.
   localparam logic [39:0] FONT_5X7 [96] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
      40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
      40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
      40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
      40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
      40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
      40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
      40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
      40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
      40'h7C14141408, 40'h081414147C, 40'h7C08040408, 40'h4854545420,
      40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
      40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
      40'h00007F0000, 40'h0041360800, 40'h0804081008, 40'h0000000000
   };

   disp_byte_type expected_bytes [$];
   logic [6:0] shadow_column;
   logic [2:0] shadow_page;

   initial begin
      fail_count    = 0;
      outstanding   = 0;
      bytes_checked = 0;
      shadow_column = '0;
      shadow_page   = '0;
   end

   task automatic report(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      fail_count = fail_count + 1;
   endtask

   task automatic push_byte(input logic is_data, input logic [7:0] value);
      expected_bytes.push_back('{is_data: is_data, value: value, last: 1'b0});
   endtask

   // Column 0 of the next page, followed by the three cursor commands.
   task automatic advance_page();
      shadow_column = '0;
      if (int'(shadow_page) + 1 >= PAGE_COUNT) begin
         shadow_page = '0;
      end else begin
         shadow_page = shadow_page + 3'd1;
      end
      push_byte(1'b0, CMD_PAGE_BASE + {5'd0, shadow_page});
      push_byte(1'b0, CMD_COL_LOW + {4'd0, shadow_column[3:0]});
      push_byte(1'b0, CMD_COL_HIGH + {5'd0, shadow_column[6:4]});
   endtask

   task automatic predict_char(input logic [7:0] code);
      logic [7:0] shown;
      int         row;
      if (code == CHAR_CR) return;
      if (code == CHAR_LF) begin
         advance_page();
      end else begin
         shown = (code < GLYPH_FIRST || code > GLYPH_LAST) ? CHAR_QUESTION : code;
         row   = int'(shown) - int'(GLYPH_FIRST);
         for (int i = 0; i < 5; i++) begin
            push_byte(1'b1, FONT_5X7[row][39 - 8*i -: 8]);
         end
         push_byte(1'b1, BLANK_COLUMN);
         shadow_column = shadow_column + CHAR_ADVANCE;
         if (int'(shadow_column) >= DISPLAY_WIDTH - 6) advance_page();
      end
      expected_bytes[expected_bytes.size() - 1].last = 1'b1;
   endtask

   always @(posedge clock) begin : watch
      disp_byte_type got;
      disp_byte_type want;
      if (reset) begin
         expected_bytes.delete();
         shadow_column = '0;
         shadow_page   = '0;
         outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{is_data: rsp_is_data, value: rsp_byte_value, last: rsp_last};
            bytes_checked = bytes_checked + 1;
            if (expected_bytes.size() == 0) begin
               report($sformatf("byte with nothing expected: is_data=%b value=%02h last=%b",
                                got.is_data, got.value, got.last));
            end else begin
               want = expected_bytes.pop_front();
               if (got !== want) begin
                  report($sformatf("is_data=%b value=%02h last=%b, expected %b %02h %b",
                                   got.is_data, got.value, got.last,
                                   want.is_data, want.value, want.last));
               end
            end
         end
         if (req_valid && req_ready) predict_char(req_char_code);
         if (drain_done && expected_bytes.size() != 0) begin
            report($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
         end
         outstanding <= expected_bytes.size();
      end
   end

endmodule

// File: tb/tb_text_to_oled_page_renderer.sv
`timescale 1ns / 1ps
// Top of the testbench for the text page renderer: clock, reset, stimulus and verdict.
// Depends on totpr_pkg, the renderer RTL and renderer_byte_checker.
module tb_text_to_oled_page_renderer
   import totpr_pkg::*;
();

   localparam int DISPLAY_WIDTH = 128;
   localparam int PAGE_COUNT    = 8;
   localparam int RANDOM_CHARS  = 140;   // per idling phase, carriage returns not counted

   // Directed characters: carriage return, line feed at column 0, the edges of the
   // printable range, the blank glyph at 0x7F, unprintable bytes at both ends of the
   // code space, and enough line feeds to wrap the page back to 0.
   localparam logic [7:0] DIRECTED [22] = '{
      CHAR_CR, CHAR_LF, CHAR_LF, GLYPH_FIRST, GLYPH_LAST, 8'h7E, 8'h3F, 8'h00,
      8'h1F, 8'h80, 8'hFF, 8'h09, 8'h0C, 8'h0E, 8'h41, 8'h61,
      CHAR_LF, CHAR_LF, CHAR_LF, CHAR_LF, CHAR_LF, CHAR_LF
   };

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_char_code;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_is_data;
   logic [7:0] rsp_byte_value;
   logic       rsp_last;
   logic       drain_done;

   int fail_count;
   int outstanding;
   int bytes_checked;

   // Idling rates in percent, changed only while the block is drained.
   int send_idle_pct;
   int rsp_idle_pct;

   int chars_sent;
   int feeds_sent;
   int odd_sent;

   text_to_oled_page_renderer #(
      .DISPLAY_WIDTH(DISPLAY_WIDTH),
      .PAGE_COUNT   (PAGE_COUNT)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_is_data   (rsp_is_data),
      .rsp_byte_value(rsp_byte_value),
      .rsp_last      (rsp_last)
   );

   // The checker sits beside the block, predicts every byte and counts failures.
   renderer_byte_checker #(
      .DISPLAY_WIDTH(DISPLAY_WIDTH),
      .PAGE_COUNT   (PAGE_COUNT)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_is_data   (rsp_is_data),
      .rsp_byte_value(rsp_byte_value),
      .rsp_last      (rsp_last),
      .drain_done    (drain_done),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .bytes_checked (bytes_checked)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver draws a fresh ready every cycle, so its stalls fall on every
   // position of a character's byte sequence.
   initial rsp_ready = 1'b0;
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // One character transfer. Idle cycles are only inserted before valid is raised;
   // once raised, valid and the character hold until the transfer happens. When the
   // task returns at the accepting edge, the caller either raises valid again for
   // the next character or lowers it, never both in one step.
   task automatic send_char(input logic [7:0] code);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= code;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (code != CHAR_CR) chars_sent = chars_sent + 1;
      if (code == CHAR_LF) feeds_sent = feeds_sent + 1;
      if (code != CHAR_LF && code != CHAR_CR && (code < GLYPH_FIRST || code > GLYPH_LAST)) begin
         odd_sent = odd_sent + 1;
      end
   endtask

   // The sender holds off until every predicted byte has come out. The first edge
   // lets the checker account for a transfer taken at the edge the task began on.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Mostly printable text, so lines fill up and wrap; line feeds are rare enough
   // that many lines run to the right edge. The rest are carriage returns and
   // unprintable bytes from both the control range and the upper half.
   function automatic logic [7:0] pick_char();
      int         roll;
      logic [7:0] code;
      roll = $urandom_range(99);
      if (roll < 82) begin
         code = 8'($urandom_range(32, 127));
      end else if (roll < 86) begin
         code = CHAR_LF;
      end else if (roll < 90) begin
         code = CHAR_CR;
      end else if ($urandom_range(1) == 0) begin
         code = 8'($urandom_range(0, 31));
         if (code == CHAR_LF || code == CHAR_CR) code = 8'h1B;
      end else begin
         code = 8'($urandom_range(128, 255));
      end
      return code;
   endfunction

   initial begin : stimulus
      logic [7:0] code;
      int         target;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_char_code = 8'h00;
      drain_done    = 1'b0;
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      chars_sent    = 0;
      feeds_sent    = 0;
      odd_sent      = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Three idling phases: a slow receiver, then a slow sender, then full speed.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 21;
               rsp_idle_pct  = 88;
            end
            1: begin
               send_idle_pct = 88;
               rsp_idle_pct  = 21;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
         endcase
         if (phase == 0) begin
            foreach (DIRECTED[i]) send_char(DIRECTED[i]);
            // Pressure point: nothing more goes in until every byte is out.
            wait_for_drain();
         end
         target = chars_sent + RANDOM_CHARS;
         while (chars_sent < target) begin
            code = pick_char();
            send_char(code);
         end
         wait_for_drain();
      end

      // Let any trailing activity settle, then ask the checker for leftovers.
      repeat (20) @(posedge clock);
      drain_done <= 1'b1;
      @(posedge clock);
      drain_done <= 1'b0;
      repeat (2) @(posedge clock);

      $display("Covered %0d characters (%0d line feeds, %0d unprintable), %0d bytes checked",
               chars_sent, feeds_sent, odd_sent, bytes_checked);
      $display("under a slow receiver, a slow sender and full speed, with drains between.");
      if (fail_count == 0) begin
         $display("tb_text_to_oled_page_renderer OK");
      end else begin
         $display("tb_text_to_oled_page_renderer NOT OK");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run, even with nine bytes per
   // character and a receiver that idles most of the time.
   initial begin : watchdog
      #8_000_000;
      $display("Timeout with %0d bytes still expected", outstanding);
      $display("tb_text_to_oled_page_renderer NOT OK");
      $finish;
   end

endmodule
